### hw/rtl/dgcc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the cycle check unit.
`timescale 1ns / 1ps
package dgcc_pkg;

   localparam int MAX_STEPS = 32;
   localparam int MAX_EDGES = 64;
   localparam int KEY_BITS  = 32;

   localparam int CMD_W      = 2;
   localparam int KEY_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int STEP_IDX_W = $clog2(MAX_STEPS);
   localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);
   localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int EDGE_RAM_W = 2 * STEP_IDX_W;
   localparam int FRAME_W    = STEP_IDX_W + EDGE_CNT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD_STEP = 2'd1,
      CMD_ADD_EDGE = 2'd2,
      CMD_CHECK    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MARK_WHITE = 2'd0,
      MARK_GREY  = 2'd1,
      MARK_BLACK = 2'd2
   } mark_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clear_graph;
      logic key_cmp;
      logic decide;
      logic chk_init;
      logic root_skip;
      logic root_start;
      logic root_done;
      logic frame_done;
      logic pop_load;
      logic edge_eval;
      logic cycle_hit;
      logic rsp_load;
      logic mark_sel_edge;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type op;
      logic    scan_end;
      logic    root_end;
      logic    root_white;
      logic    pos_end;
      logic    depth_last;
      logic    hit_grey;
      logic    rsp_free;
   } dp_stat_type;

endpackage

### hw/rtl/dgcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dgcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dgcc_datapath.sv
// Datapath: graph tables, search registers, colour marks and the result register.
`timescale 1ns / 1ps
module dgcc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dgcc_pkg::dp_cmd_type                dp_cmd,
   output dgcc_pkg::dp_stat_type               dp_stat,
   input  logic [dgcc_pkg::CMD_W-1:0]          req_cmd,
   input  logic [dgcc_pkg::KEY_W-1:0]          req_key_a,
   input  logic [dgcc_pkg::KEY_W-1:0]          req_key_b,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [dgcc_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_cycle_found
);
   import dgcc_pkg::*;

   cmd_type                 op_ff;
   logic [KEY_BITS-1:0]     key_a_ff, key_b_ff;
   logic [STEP_CNT_W-1:0]   step_total_ff, step_total_in;
   logic [EDGE_CNT_W-1:0]   edge_total_ff, edge_total_in;
   logic [STEP_CNT_W-1:0]   scan_ff, scan_in;
   logic                    found_a_ff, found_a_in, found_b_ff, found_b_in;
   logic [STEP_IDX_W-1:0]   idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   mark_type                marks_ff [MAX_STEPS];
   logic [STEP_CNT_W-1:0]   root_ff, root_in;
   logic [STEP_IDX_W-1:0]   cur_node_ff, cur_node_in;
   logic [EDGE_CNT_W-1:0]   cur_pos_ff, cur_pos_in;
   logic [STEP_CNT_W-1:0]   depth_ff, depth_in;
   status_type              res_status_ff, res_status_in;
   logic                    res_cycle_ff, res_cycle_in;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic                    rsp_cycle_ff;

   logic [KEY_BITS-1:0]     key_rd;
   logic [EDGE_RAM_W-1:0]   edge_rd;
   logic [FRAME_W-1:0]      frame_rd;
   logic                    key_we, edge_we, push;
   logic [STEP_IDX_W-1:0]   edge_src, edge_tgt, mark_idx;
   mark_type                mark_rd;
   logic [EDGE_CNT_W-1:0]   pos_next;
   logic [STEP_CNT_W-1:0]   depth_m1, depth_m2;

   assign edge_src = edge_rd[EDGE_RAM_W-1 -: STEP_IDX_W];
   assign edge_tgt = edge_rd[STEP_IDX_W-1:0];
   assign mark_idx = dp_cmd.mark_sel_edge ? edge_tgt : root_ff[STEP_IDX_W-1:0];
   assign mark_rd  = marks_ff[mark_idx];
   assign pos_next = cur_pos_ff + EDGE_CNT_W'(1);
   assign depth_m1 = depth_ff - STEP_CNT_W'(1);
   assign depth_m2 = depth_ff - STEP_CNT_W'(2);
   assign push     = dp_cmd.edge_eval && (edge_src == cur_node_ff)
                     && (mark_rd == MARK_WHITE) && (depth_ff < STEP_CNT_W'(MAX_STEPS));

   dgcc_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_STEPS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (step_total_ff[STEP_IDX_W-1:0]),
      .wr_data (key_a_ff),
      .rd_addr (scan_ff[STEP_IDX_W-1:0]),
      .rd_data (key_rd)
   );

   dgcc_ram #(.WIDTH(EDGE_RAM_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_total_ff[EDGE_IDX_W-1:0]),
      .wr_data ({idx_a_ff, idx_b_ff}),
      .rd_addr (cur_pos_ff[EDGE_IDX_W-1:0]),
      .rd_data (edge_rd)
   );

   dgcc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_STEPS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (depth_m1[STEP_IDX_W-1:0]),
      .wr_data ({cur_node_ff, pos_next}),
      .rd_addr (depth_m2[STEP_IDX_W-1:0]),
      .rd_data (frame_rd)
   );

   always_comb begin
      step_total_in = step_total_ff;
      edge_total_in = edge_total_ff;
      scan_in       = scan_ff;
      found_a_in    = found_a_ff;
      found_b_in    = found_b_ff;
      idx_a_in      = idx_a_ff;
      idx_b_in      = idx_b_ff;
      root_in       = root_ff;
      cur_node_in   = cur_node_ff;
      cur_pos_in    = cur_pos_ff;
      depth_in      = depth_ff;
      res_status_in = res_status_ff;
      res_cycle_in  = res_cycle_ff;
      key_we        = 1'b0;
      edge_we       = 1'b0;

      if (dp_cmd.capture) begin
         scan_in    = '0;
         found_a_in = 1'b0;
         found_b_in = 1'b0;
      end
      if (dp_cmd.clear_graph) begin
         step_total_in = '0;
         edge_total_in = '0;
         res_status_in = ST_OK;
         res_cycle_in  = 1'b0;
      end
      if (dp_cmd.key_cmp) begin
         scan_in = scan_ff + STEP_CNT_W'(1);
         if (key_rd == key_a_ff) begin
            found_a_in = 1'b1;
            idx_a_in   = scan_ff[STEP_IDX_W-1:0];
         end
         if (key_rd == key_b_ff) begin
            found_b_in = 1'b1;
            idx_b_in   = scan_ff[STEP_IDX_W-1:0];
         end
      end
      if (dp_cmd.decide) begin
         res_cycle_in = 1'b0;
         if (op_ff == CMD_ADD_STEP) begin
            if (found_a_ff) begin
               res_status_in = ST_EXISTS;
            end else if (step_total_ff >= STEP_CNT_W'(MAX_STEPS)) begin
               res_status_in = ST_FULL;
            end else begin
               res_status_in = ST_OK;
               key_we        = 1'b1;
               step_total_in = step_total_ff + STEP_CNT_W'(1);
            end
         end else begin
            if (!found_a_ff || !found_b_ff) begin
               res_status_in = ST_NOT_FOUND;
            end else if (key_a_ff == key_b_ff) begin
               res_status_in = ST_INVALID;
            end else if (edge_total_ff >= EDGE_CNT_W'(MAX_EDGES)) begin
               res_status_in = ST_FULL;
            end else begin
               res_status_in = ST_OK;
               edge_we       = 1'b1;
               edge_total_in = edge_total_ff + EDGE_CNT_W'(1);
            end
         end
      end
      if (dp_cmd.chk_init) begin
         root_in = '0;
      end
      if (dp_cmd.root_skip) begin
         root_in = root_ff + STEP_CNT_W'(1);
      end
      if (dp_cmd.root_start) begin
         cur_node_in = root_ff[STEP_IDX_W-1:0];
         cur_pos_in  = '0;
         depth_in    = STEP_CNT_W'(1);
      end
      if (dp_cmd.root_done) begin
         res_status_in = ST_OK;
         res_cycle_in  = 1'b0;
      end
      if (dp_cmd.frame_done) begin
         depth_in = depth_m1;
         if (depth_ff == STEP_CNT_W'(1)) begin
            root_in = root_ff + STEP_CNT_W'(1);
         end
      end
      if (dp_cmd.pop_load) begin
         cur_node_in = frame_rd[FRAME_W-1 -: STEP_IDX_W];
         cur_pos_in  = frame_rd[EDGE_CNT_W-1:0];
      end
      if (dp_cmd.edge_eval) begin
         if (push) begin
            cur_node_in = edge_tgt;
            cur_pos_in  = '0;
            depth_in    = depth_ff + STEP_CNT_W'(1);
         end else begin
            cur_pos_in = pos_next;
         end
      end
      if (dp_cmd.cycle_hit) begin
         res_status_in = ST_OK;
         res_cycle_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_total_ff <= '0;
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_total_ff <= step_total_in;
         edge_total_ff <= edge_total_in;
         if (dp_cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff    <= cmd_type'(req_cmd);
         key_a_ff <= req_key_a[KEY_BITS-1:0];
         key_b_ff <= req_key_b[KEY_BITS-1:0];
      end
      scan_ff       <= scan_in;
      found_a_ff    <= found_a_in;
      found_b_ff    <= found_b_in;
      idx_a_ff      <= idx_a_in;
      idx_b_ff      <= idx_b_in;
      root_ff       <= root_in;
      cur_node_ff   <= cur_node_in;
      cur_pos_ff    <= cur_pos_in;
      depth_ff      <= depth_in;
      res_status_ff <= res_status_in;
      res_cycle_ff  <= res_cycle_in;
      if (dp_cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_cycle_ff  <= res_cycle_ff;
      end
   end

   // Colour marks: cleared together at the start of a check, one entry written per cycle.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_STEPS; i++) begin
         if (dp_cmd.chk_init) begin
            marks_ff[i] <= MARK_WHITE;
         end
      end
      if (dp_cmd.root_start) begin
         marks_ff[root_ff[STEP_IDX_W-1:0]] <= MARK_GREY;
      end
      if (dp_cmd.frame_done) begin
         marks_ff[cur_node_ff] <= MARK_BLACK;
      end
      if (push) begin
         marks_ff[edge_tgt] <= MARK_GREY;
      end
   end

   assign dp_stat.op         = op_ff;
   assign dp_stat.scan_end   = (scan_ff >= step_total_ff);
   assign dp_stat.root_end   = (root_ff >= step_total_ff);
   assign dp_stat.root_white = (mark_rd == MARK_WHITE);
   assign dp_stat.pos_end    = (cur_pos_ff >= edge_total_ff);
   assign dp_stat.depth_last = (depth_ff == STEP_CNT_W'(1));
   assign dp_stat.hit_grey   = (edge_src == cur_node_ff) && (mark_rd == MARK_GREY);
   assign dp_stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cycle_found = rsp_cycle_ff;

endmodule

### hw/rtl/dgcc_ctrl.sv
// Controller state machine that sequences the key scan, table updates and depth-first search.
`timescale 1ns / 1ps
module dgcc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dgcc_pkg::dp_stat_type dp_stat,
   output dgcc_pkg::dp_cmd_type  dp_cmd
);
   import dgcc_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DISPATCH = 10'b00_0000_0010,
      S_KEY_RD   = 10'b00_0000_0100,
      S_KEY_CMP  = 10'b00_0000_1000,
      S_DECIDE   = 10'b00_0001_0000,
      S_ROOT     = 10'b00_0010_0000,
      S_EDGE     = 10'b00_0100_0000,
      S_ECHK     = 10'b00_1000_0000,
      S_POP      = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (dp_stat.op)
               CMD_CLEAR: begin
                  dp_cmd.clear_graph = 1'b1;
                  state_in           = S_RESP;
               end
               CMD_CHECK: begin
                  dp_cmd.chk_init = 1'b1;
                  state_in        = S_ROOT;
               end
               default: state_in = S_KEY_RD;
            endcase
         end
         S_KEY_RD: begin
            state_in = dp_stat.scan_end ? S_DECIDE : S_KEY_CMP;
         end
         S_KEY_CMP: begin
            dp_cmd.key_cmp = 1'b1;
            state_in       = S_KEY_RD;
         end
         S_DECIDE: begin
            dp_cmd.decide = 1'b1;
            state_in      = S_RESP;
         end
         S_ROOT: begin
            if (dp_stat.root_end) begin
               dp_cmd.root_done = 1'b1;
               state_in         = S_RESP;
            end else if (dp_stat.root_white) begin
               dp_cmd.root_start = 1'b1;
               state_in          = S_EDGE;
            end else begin
               dp_cmd.root_skip = 1'b1;
            end
         end
         S_EDGE: begin
            if (dp_stat.pos_end) begin
               dp_cmd.frame_done = 1'b1;
               state_in          = dp_stat.depth_last ? S_ROOT : S_POP;
            end else begin
               state_in = S_ECHK;
            end
         end
         S_ECHK: begin
            dp_cmd.mark_sel_edge = 1'b1;
            if (dp_stat.hit_grey) begin
               dp_cmd.cycle_hit = 1'b1;
               state_in         = S_RESP;
            end else begin
               dp_cmd.edge_eval = 1'b1;
               state_in         = S_EDGE;
            end
         end
         S_POP: begin
            dp_cmd.pop_load = 1'b1;
            state_in        = S_EDGE;
         end
         S_RESP: begin
            if (dp_stat.rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### hw/rtl/dependency_graph_cycle_check_unit.sv
// Top level of the dependency graph cycle check unit: controller plus datapath.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         req_valid/req_stall   req_cmd, req_key_a, req_key_b
//   rsp_*     out        rsp_valid/rsp_stall   rsp_status, rsp_cycle_found
//
// One transaction is worked on at a time. The time an add takes is set by the key
// scan through the key RAM; the time a check takes is set by the edge RAM, which
// is read one edge at a time for each search frame.
// Reset is synchronous and empties the graph; no clearing pass is needed.
// A new request transaction is taken while a finished result still waits on a
// stalled response channel; the result register holds it until it is taken.
`timescale 1ns / 1ps
module dependency_graph_cycle_check_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dgcc_pkg::CMD_W-1:0]    req_cmd,
   input  logic [dgcc_pkg::KEY_W-1:0]    req_key_a,
   input  logic [dgcc_pkg::KEY_W-1:0]    req_key_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dgcc_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_cycle_found
);
   import dgcc_pkg::*;

   // Commands run from the controller to the datapath, status runs back.
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   dgcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // The datapath holds the key, edge and stack RAMs, the colour marks and the
   // response register.
   dgcc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .req_cmd         (req_cmd),
      .req_key_a       (req_key_a),
      .req_key_b       (req_key_b),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_cycle_found (rsp_cycle_found)
   );

endmodule
